// ===== sv/nchc_pkg.sv =====
// ----------------------------------------------------------------------------
// nchc_pkg: shared types and constants of the neighbor cache
// Status codes, modes, register indexes and the queue payload type.
// ----------------------------------------------------------------------------
`default_nettype none
package nchc_pkg;

   localparam int ENTRY_DEPTH_DEF = 64;
   localparam int HOST_DEPTH_DEF  = 32;
   localparam int LINK_BYTES_DEF  = 8;

   localparam logic [15:0] REJECT_MASK_RESET = 16'd97;
   localparam logic [31:0] MAX_AGE_RESET     = 32'd90;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [3:0] ST_TICK      = 4'd0;
   localparam logic [3:0] ST_ADDED     = 4'd1;
   localparam logic [3:0] ST_REFRESHED = 4'd2;
   localparam logic [3:0] ST_IGNORED   = 4'd3;
   localparam logic [3:0] ST_ENT_FULL  = 4'd4;
   localparam logic [3:0] ST_HOST_FULL = 4'd5;
   localparam logic [3:0] ST_LINK_LONG = 4'd6;
   localparam logic [3:0] ST_FRESH     = 4'd7;
   localparam logic [3:0] ST_STALE     = 4'd8;
   localparam logic [3:0] ST_MISS      = 4'd9;

   localparam logic [0:0] CSR_REJECT_MASK = 1'd0;
   localparam logic [0:0] CSR_MAX_AGE     = 1'd1;

   // classified command handed from front to back
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_LOOKUP,
      CMD_UPDATE,
      CMD_IGNORE
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        is_ipv6;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [63:0] link_addr;
      logic [3:0]  link_len;
   } job_type;

   function automatic logic [63:0] link_mask(input logic [3:0] len);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (len > 4'(b)) begin
            m[b*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== sv/nchc_req_if.sv =====
// ----------------------------------------------------------------------------
// nchc_req_if: request channel
// Valid/ready channel carrying one neighbor cache command beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface nchc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        is_new_message;
   logic [15:0] neighbor_state;
   logic        has_link_addr;
   logic        is_ipv6;
   logic [63:0] address_high;
   logic [63:0] address_low;
   logic [63:0] link_addr;
   logic [3:0]  link_len;

   modport source (output valid, mode, is_new_message, neighbor_state, has_link_addr,
      is_ipv6, address_high, address_low, link_addr, link_len, input ready);
   modport sink (input valid, mode, is_new_message, neighbor_state, has_link_addr,
      is_ipv6, address_high, address_low, link_addr, link_len, output ready);
endinterface
`default_nettype wire

// ===== sv/nchc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nchc_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface nchc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [5:0]  entry_index;
   logic [4:0]  host_index;
   logic [63:0] host_link_out;
   logic [3:0]  host_link_len_out;
   logic        new_host;

   modport source (output valid, status, entry_index, host_index, host_link_out,
      host_link_len_out, new_host, input ready);
   modport sink (input valid, status, entry_index, host_index, host_link_out,
      host_link_len_out, new_host, output ready);
endinterface
`default_nettype wire

// ===== sv/nchc_front.sv =====
// ----------------------------------------------------------------------------
// nchc_front: request classifier
// Takes request beats, applies the reject filter and pushes jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module nchc_front
   import nchc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   nchc_req_if.sink    req,
   input  wire logic [15:0] reject_mask,
   output logic        job_push,
   output job_type     job_data,
   input  wire logic   job_full
);

   always_comb begin
      req.ready = !job_full;
      job_push  = req.valid && !job_full;
      job_data.is_ipv6      = req.is_ipv6;
      job_data.address_high = req.is_ipv6 ? req.address_high : 64'd0;
      job_data.address_low  = req.is_ipv6 ? req.address_low
                                          : {32'd0, req.address_low[31:0]};
      job_data.link_addr    = req.link_addr & link_mask(req.link_len);
      job_data.link_len     = req.link_len;
      case (req.mode)
         MODE_TICK:   job_data.cmd = CMD_TICK;
         MODE_LOOKUP: job_data.cmd = CMD_LOOKUP;
         MODE_UPDATE: job_data.cmd = (req.is_new_message && req.has_link_addr &&
                         (req.neighbor_state & reject_mask) == 16'd0) ? CMD_UPDATE
                                                                     : CMD_IGNORE;
         default:     job_data.cmd = CMD_IGNORE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (!(job_push && job_full)) else $error("push into full queue");
      end
   end

endmodule
`default_nettype wire

// ===== sv/nchc_queue.sv =====
// ----------------------------------------------------------------------------
// nchc_queue: job queue
// Two-entry FIFO between classifier and table engine.
// ----------------------------------------------------------------------------
`default_nettype none
module nchc_queue
   import nchc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_data,
   output logic      full,
   input  wire logic pop,
   output logic      not_empty,
   output job_type   pop_data
);

   job_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      full      = cnt_ff == 2'd2;
      not_empty = cnt_ff != 2'd0;
      pop_data  = slot_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== sv/nchc_back.sv =====
// ----------------------------------------------------------------------------
// nchc_back: table engine
// Walks entry and host tables one row at a time; appends and refreshes rows.
// ----------------------------------------------------------------------------
`default_nettype none
module nchc_back
   import nchc_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF,
   parameter int HOST_DEPTH  = HOST_DEPTH_DEF,
   parameter int LINK_BYTES  = LINK_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic job_valid,
   input  job_type   job_data,
   output logic      job_pop,
   input  wire logic [31:0] max_age,
   nchc_rsp_if.source rsp
);

   localparam int EW = $clog2(ENTRY_DEPTH);
   localparam int HW = $clog2(HOST_DEPTH);
   localparam int EC = $clog2(ENTRY_DEPTH + 1);
   localparam int HC = $clog2(HOST_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_ESCAN, S_EREAD, S_HSCAN, S_HREAD, S_APPEND, S_OUT
   } state_type;

   // entry memory row: family, address, owner (chain link kept separately)
   typedef struct packed {
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [HW-1:0] owner;
   } erow_type;

   erow_type        emem [ENTRY_DEPTH];
   logic [31:0]     stamp_mem [ENTRY_DEPTH];
   logic [EC-1:0]   next_mem [ENTRY_DEPTH];
   logic [63:0]     hlink_mem [HOST_DEPTH];
   logic [3:0]      hlen_mem [HOST_DEPTH];
   logic [EC-1:0]   head_mem [HOST_DEPTH];

   state_type     state_ff;
   job_type       job_ff;
   logic [31:0]   time_ff;
   logic [EC-1:0] ecount_ff;
   logic [HC-1:0] hcount_ff;
   logic [EC-1:0] eptr_ff;
   logic [HC-1:0] hptr_ff;
   erow_type      erd_ff;
   logic [31:0]   srd_ff;
   logic [63:0]   hlrd_ff;
   logic [3:0]    hnrd_ff;
   logic [EC-1:0] headrd_ff;
   logic [HW-1:0] hsel_ff;
   logic          newh_ff;
   logic          rvalid_ff;
   logic [3:0]    rstatus_ff;
   logic [5:0]    reidx_ff;
   logic [4:0]    rhidx_ff;
   logic [63:0]   rlink_ff;
   logic [3:0]    rlen_ff;
   logic          rnew_ff;
   logic          ematch;

   always_comb begin
      ematch = erd_ff.v6 == job_ff.is_ipv6 && erd_ff.lo == job_ff.address_low &&
               erd_ff.hi == job_ff.address_high;
      job_pop = state_ff == S_IDLE && job_valid && !rvalid_ff;
      rsp.valid             = rvalid_ff;
      rsp.status            = rstatus_ff;
      rsp.entry_index       = reidx_ff;
      rsp.host_index        = rhidx_ff;
      rsp.host_link_out     = rlink_ff;
      rsp.host_link_len_out = rlen_ff;
      rsp.new_host          = rnew_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      erd_ff    <= emem[eptr_ff[EW-1:0]];
      srd_ff    <= stamp_mem[eptr_ff[EW-1:0]];
      hlrd_ff   <= hlink_mem[hptr_ff[HW-1:0]];
      hnrd_ff   <= hlen_mem[hptr_ff[HW-1:0]];
      headrd_ff <= head_mem[hptr_ff[HW-1:0]];
      if (state_ff == S_APPEND) begin
         emem[ecount_ff[EW-1:0]]      <= '{v6: job_ff.is_ipv6, hi: job_ff.address_high,
                                           lo: job_ff.address_low, owner: hsel_ff};
         stamp_mem[ecount_ff[EW-1:0]] <= time_ff;
         next_mem[ecount_ff[EW-1:0]]  <= newh_ff ? EC'(ENTRY_DEPTH) : headrd_ff;
         head_mem[hsel_ff]            <= ecount_ff;
         if (newh_ff) begin
            hlink_mem[hsel_ff] <= job_ff.link_addr;
            hlen_mem[hsel_ff]  <= job_ff.link_len;
         end
      end
      if (state_ff == S_EREAD && ematch && job_ff.cmd == CMD_UPDATE) begin
         stamp_mem[eptr_ff[EW-1:0]] <= time_ff;
      end
   end

   task automatic finish(input logic [3:0] st);
      rvalid_ff  <= 1'b1;
      rstatus_ff <= st;
      state_ff   <= S_IDLE;
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         time_ff   <= '0;
         ecount_ff <= '0;
         hcount_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_pop) begin
                  job_ff    <= job_data;
                  eptr_ff   <= '0;
                  hptr_ff   <= '0;
                  reidx_ff  <= '0;
                  rhidx_ff  <= '0;
                  rlink_ff  <= '0;
                  rlen_ff   <= '0;
                  rnew_ff   <= 1'b0;
                  case (job_data.cmd)
                     CMD_TICK: begin
                        time_ff <= time_ff + 32'd1;
                        finish(ST_TICK);
                     end
                     CMD_IGNORE: finish(ST_IGNORED);
                     default: state_ff <= S_ESCAN;
                  endcase
               end
            end
            S_ESCAN: begin
               if (eptr_ff >= ecount_ff) begin
                  if (job_ff.cmd == CMD_LOOKUP) begin
                     finish(ST_MISS);
                  end else if (ecount_ff >= EC'(ENTRY_DEPTH)) begin
                     finish(ST_ENT_FULL);
                  end else begin
                     state_ff <= S_HSCAN;
                  end
               end else begin
                  state_ff <= S_EREAD;
               end
            end
            S_EREAD: begin
               if (ematch) begin
                  reidx_ff <= 6'(eptr_ff);
                  rhidx_ff <= 5'(erd_ff.owner);
                  hptr_ff  <= HC'(erd_ff.owner);
                  if (job_ff.cmd == CMD_UPDATE) begin
                     finish(ST_REFRESHED);
                  end else begin
                     state_ff <= S_HREAD;
                  end
               end else begin
                  eptr_ff  <= eptr_ff + EC'(1);
                  state_ff <= S_ESCAN;
               end
            end
            S_HREAD: begin
               if (job_ff.cmd == CMD_LOOKUP) begin
                  state_ff <= S_OUT;
               end else if (hlrd_ff == job_ff.link_addr && hnrd_ff == job_ff.link_len) begin
                  hsel_ff  <= hptr_ff[HW-1:0];
                  newh_ff  <= 1'b0;
                  state_ff <= S_APPEND;
               end else begin
                  hptr_ff  <= hptr_ff + HC'(1);
                  state_ff <= S_HSCAN;
               end
            end
            S_OUT: begin
               rlink_ff <= hlrd_ff;
               rlen_ff  <= hnrd_ff;
               finish((time_ff - srd_ff) < max_age ? ST_FRESH : ST_STALE);
            end
            S_HSCAN: begin
               if (job_ff.link_len > 4'(LINK_BYTES)) begin
                  finish(ST_LINK_LONG);
               end else if (hptr_ff >= hcount_ff) begin
                  if (hcount_ff >= HC'(HOST_DEPTH)) begin
                     finish(ST_HOST_FULL);
                  end else begin
                     hsel_ff   <= hcount_ff[HW-1:0];
                     newh_ff   <= 1'b1;
                     hcount_ff <= hcount_ff + HC'(1);
                     state_ff  <= S_APPEND;
                  end
               end else begin
                  state_ff <= S_HREAD;
               end
            end
            S_APPEND: begin
               reidx_ff  <= 6'(ecount_ff);
               rhidx_ff  <= 5'(hsel_ff);
               rnew_ff   <= newh_ff;
               ecount_ff <= ecount_ff + EC'(1);
               finish(ST_ADDED);
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) ecount_ff <= EC'(ENTRY_DEPTH))
      else $error("entry count overflow");
   assert property (@(posedge clock) disable iff (reset) hcount_ff <= HC'(HOST_DEPTH))
      else $error("host count overflow");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPEND |=> ecount_ff == $past(ecount_ff) + EC'(1))
      else $error("append did not grow the table");
   assert property (@(posedge clock) disable iff (reset) !(job_pop && rvalid_ff))
      else $error("new job while result pending");

endmodule
`default_nettype wire

// ===== sv/neighbor_cache_with_host_chains.sv =====
// ----------------------------------------------------------------------------
// neighbor_cache_with_host_chains: neighbor cache with host chains and aging
// A tick or ignored update completes without a table walk. Lookup and update
// walk the entry table one row at a time, then an update that adds walks the
// host table; a lookup hit adds a host read. Single-port table reads in the
// engine set the rate. A two-entry queue lets requests be taken while the
// engine works.
// ----------------------------------------------------------------------------
`default_nettype none
module neighbor_cache_with_host_chains
   import nchc_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF,
   parameter int HOST_DEPTH  = HOST_DEPTH_DEF,
   parameter int LINK_BYTES  = LINK_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   nchc_req_if.sink         req,
   nchc_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   logic [15:0] reject_mask_ff;
   logic [31:0] max_age_ff;
   logic        push, full, pop, not_empty;
   job_type     push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_mask_ff <= REJECT_MASK_RESET;
         max_age_ff     <= MAX_AGE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REJECT_MASK: reject_mask_ff <= csr_write_data[15:0];
            CSR_MAX_AGE:     max_age_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   nchc_front u_front (
      .clock, .reset, .req, .reject_mask(reject_mask_ff),
      .job_push(push), .job_data(push_data), .job_full(full)
   );

   nchc_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .not_empty, .pop_data
   );

   nchc_back #(
      .ENTRY_DEPTH(ENTRY_DEPTH), .HOST_DEPTH(HOST_DEPTH), .LINK_BYTES(LINK_BYTES)
   ) u_back (
      .clock, .reset, .job_valid(not_empty), .job_data(pop_data), .job_pop(pop),
      .max_age(max_age_ff), .rsp
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the neighbor cache with host chains
// Drives updates, lookups and ticks over the request channel, with random gaps
// on both sides. A built-in cache model predicts every result beat, and the
// monitor compares each one field by field. The tables are filled to their
// limits, and the reject mask and age limit are changed between phases.
// ----------------------------------------------------------------------------
module tb_top
   import nchc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = ENTRY_DEPTH_DEF;
   localparam int HOST_SLOTS  = HOST_DEPTH_DEF;
   localparam int MAX_LINK    = LINK_BYTES_DEF;
   localparam int DRAIN_WAIT  = 400;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic        is_new;
      logic [15:0] nstate;
      logic        has_link;
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] link;
      logic [3:0]  llen;
      bit          drain;
   } req_beat_type;

   typedef struct {
      logic [3:0]  status;
      logic [5:0]  eidx;
      logic [4:0]  hidx;
      logic [63:0] hlink;
      logic [3:0]  hlen;
      logic        nh;
   } rsp_beat_type;

   logic clock;
   logic reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [31:0] csr_write_data;

   nchc_req_if req_ch ();
   nchc_rsp_if rsp_ch ();

   neighbor_cache_with_host_chains uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // cache model state
   logic [15:0] mdl_reject;
   logic [31:0] mdl_max_age;
   logic [31:0] mdl_now;
   int          mdl_entries;
   int          mdl_hosts;
   logic        ent_v6    [NUM_ENTRIES];
   logic [63:0] ent_hi    [NUM_ENTRIES];
   logic [63:0] ent_lo    [NUM_ENTRIES];
   logic [31:0] ent_stamp [NUM_ENTRIES];
   int          ent_owner [NUM_ENTRIES];
   int          ent_next  [NUM_ENTRIES];
   logic [63:0] host_link [HOST_SLOTS];
   logic [3:0]  host_len  [HOST_SLOTS];
   int          host_head [HOST_SLOTS];

   req_beat_type pending_beats[$];
   rsp_beat_type expected_rsps[$];
   int        errors;
   int        beats_checked;
   int        status_seen [16];
   logic [63:0] addr_pool [80];
   logic [63:0] link_pool [48];
   logic [3:0]  len_pool  [48];

   function automatic logic [63:0] bytes_mask(input logic [3:0] len);
      if (len >= 8) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   function automatic int find_entry(input logic v6, input logic [63:0] hi,
                                     input logic [63:0] lo);
      for (int i = 0; i < mdl_entries; i++) begin
         if (ent_v6[i] == v6) begin
            if (v6 && ent_hi[i] == hi && ent_lo[i] == lo) return i;
            if (!v6 && ent_lo[i] == {32'd0, lo[31:0]}) return i;
         end
      end
      return -1;
   endfunction

   function automatic int host_lookup(input logic [63:0] link, input logic [3:0] len);
      if (len > MAX_LINK) return -1;
      for (int i = 0; i < mdl_hosts; i++)
         if (host_len[i] == len && host_link[i] == (link & bytes_mask(len))) return i;
      return -1;
   endfunction

   function automatic rsp_beat_type cache_predict(input req_beat_type b);
      rsp_beat_type r;
      int e;
      int h;
      r = '{status: ST_IGNORED, eidx: '0, hidx: '0, hlink: '0, hlen: '0, nh: 1'b0};
      case (b.mode)
         MODE_TICK: begin
            mdl_now = mdl_now + 32'd1;
            r.status = ST_TICK;
         end
         MODE_LOOKUP: begin
            e = find_entry(b.v6, b.hi, b.lo);
            if (e < 0) begin
               r.status = ST_MISS;
            end else begin
               r.eidx = e[5:0];
               r.hidx = ent_owner[e][4:0];
               r.hlink = host_link[ent_owner[e]];
               r.hlen = host_len[ent_owner[e]];
               r.status = (32'(mdl_now - ent_stamp[e]) < mdl_max_age) ? ST_FRESH : ST_STALE;
            end
         end
         MODE_UPDATE: begin
            if (b.is_new && b.has_link && (b.nstate & mdl_reject) == 16'd0) begin
               e = find_entry(b.v6, b.hi, b.lo);
               if (e >= 0) begin
                  ent_stamp[e] = mdl_now;
                  r.eidx = e[5:0];
                  r.hidx = ent_owner[e][4:0];
                  r.status = ST_REFRESHED;
               end else if (mdl_entries >= NUM_ENTRIES) begin
                  r.status = ST_ENT_FULL;
               end else begin
                  h = host_lookup(b.link, b.llen);
                  if (h < 0) begin
                     if (b.llen > MAX_LINK) begin
                        r.status = ST_LINK_LONG;
                     end else if (mdl_hosts >= HOST_SLOTS) begin
                        r.status = ST_HOST_FULL;
                     end else begin
                        h = mdl_hosts;
                        host_link[h] = b.link & bytes_mask(b.llen);
                        host_len[h] = b.llen;
                        host_head[h] = NUM_ENTRIES;
                        mdl_hosts++;
                        r.nh = 1'b1;
                     end
                  end
                  if (h >= 0) begin
                     e = mdl_entries;
                     ent_v6[e] = b.v6;
                     ent_hi[e] = b.v6 ? b.hi : 64'd0;
                     ent_lo[e] = b.v6 ? b.lo : {32'd0, b.lo[31:0]};
                     ent_stamp[e] = mdl_now;
                     ent_owner[e] = h;
                     ent_next[e] = host_head[h];
                     host_head[h] = e;
                     mdl_entries++;
                     r.eidx = e[5:0];
                     r.hidx = h[4:0];
                     r.status = ST_ADDED;
                  end
               end
            end
         end
         default: r.status = ST_IGNORED;
      endcase
      return r;
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("MISMATCH beat %0d %s: got %0h expected %0h", beats_checked, field, got, want);
   endtask

   function automatic req_beat_type make_beat(input logic [1:0] mode);
      req_beat_type b;
      int k;
      b.mode = mode;
      b.is_new = 1'b1;
      b.has_link = 1'b1;
      b.nstate = 16'($urandom) & ~mdl_reject;
      k = $urandom_range(0, 79);
      b.v6 = k[0];
      b.hi = {$urandom, $urandom};
      b.lo = {$urandom, $urandom};
      if (b.v6) begin
         b.hi = addr_pool[k] ^ 64'h5a5a;
         b.lo = addr_pool[k];
      end else begin
         b.lo[31:0] = addr_pool[k][31:0];
      end
      if ($urandom_range(0, 9) == 0) begin
         b.hi = {$urandom, $urandom};
         b.lo = {$urandom, $urandom};
      end
      k = $urandom_range(0, 47);
      b.link = {$urandom, $urandom};
      b.link = (b.link & ~bytes_mask(len_pool[k])) | link_pool[k];
      b.llen = len_pool[k];
      if ($urandom_range(0, 19) == 0) b.llen = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) == 0) begin
         b.is_new = 1'($urandom);
         b.has_link = 1'($urandom);
         b.nstate = 16'($urandom);
      end
      b.drain = 1'b0;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return make_beat(MODE_UPDATE);
      if (r < 75) return make_beat(MODE_LOOKUP);
      if (r < 97) return make_beat(MODE_TICK);
      return make_beat(MODE_UNUSED);
   endfunction

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // driver
   int  gap_left;
   bit  calm;
   int  sent;
   always @(posedge clock) begin
      logic hold;
      req_beat_type b;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.mode <= MODE_TICK;
         req_ch.is_new_message <= 1'b0;
         req_ch.neighbor_state <= '0;
         req_ch.has_link_addr <= 1'b0;
         req_ch.is_ipv6 <= 1'b0;
         req_ch.address_high <= '0;
         req_ch.address_low <= '0;
         req_ch.link_addr <= '0;
         req_ch.link_len <= '0;
         gap_left = 0;
         calm = 0;
         sent = 0;
      end else begin
         hold = req_ch.valid && !req_ch.ready;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0 && (!pending_beats[0].drain ||
                  (expected_rsps.size() == 0 && !req_ch.valid))) begin
               b = pending_beats.pop_front();
               req_ch.mode <= b.mode;
               req_ch.is_new_message <= b.is_new;
               req_ch.neighbor_state <= b.nstate;
               req_ch.has_link_addr <= b.has_link;
               req_ch.is_ipv6 <= b.v6;
               req_ch.address_high <= b.hi;
               req_ch.address_low <= b.lo;
               req_ch.link_addr <= b.link;
               req_ch.link_len <= b.llen;
               hold = 1'b1;
               sent++;
               if (sent % 150 == 0) calm = ~calm;
               gap_left = calm ? 0 : $urandom_range(0, 19);
            end
         end
         req_ch.valid <= hold;
      end
   end

   // monitor: predicts on request beats, checks response beats
   int stall_left;
   always @(posedge clock) begin
      logic rdy;
      rsp_beat_type want;
      req_beat_type b;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            b.mode = req_ch.mode;
            b.is_new = req_ch.is_new_message;
            b.nstate = req_ch.neighbor_state;
            b.has_link = req_ch.has_link_addr;
            b.v6 = req_ch.is_ipv6;
            b.hi = req_ch.address_high;
            b.lo = req_ch.address_low;
            b.link = req_ch.link_addr;
            b.llen = req_ch.link_len;
            b.drain = 1'b0;
            expected_rsps.push_back(cache_predict(b));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_checked++;
            if (expected_rsps.size() == 0) begin
               report("unexpected beat, status", 64'(rsp_ch.status), 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               status_seen[want.status]++;
               if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
               if (rsp_ch.entry_index !== want.eidx)
                  report("entry_index", rsp_ch.entry_index, want.eidx);
               if (rsp_ch.host_index !== want.hidx)
                  report("host_index", rsp_ch.host_index, want.hidx);
               if (rsp_ch.host_link_out !== want.hlink)
                  report("host_link_out", rsp_ch.host_link_out, want.hlink);
               if (rsp_ch.host_link_len_out !== want.hlen)
                  report("host_link_len_out", rsp_ch.host_link_len_out, want.hlen);
               if (rsp_ch.new_host !== want.nh) report("new_host", rsp_ch.new_host, want.nh);
            end
            stall_left = calm ? 0 : $urandom_range(0, 19);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rdy = (stall_left == 0);
         rsp_ch.ready <= rdy;
      end
   end

   task automatic wait_idle();
      while (pending_beats.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_REJECT_MASK) mdl_reject = data[15:0];
      else mdl_max_age = data;
   endtask

   task automatic push_directed(input logic [1:0] mode, input logic is_new,
      input logic [15:0] st, input logic has_link, input logic v6, input logic [63:0] hi,
      input logic [63:0] lo, input logic [63:0] link, input logic [3:0] llen);
      pending_beats.push_back('{mode, is_new, st, has_link, v6, hi, lo, link, llen, 1'b0});
   endtask

   initial begin
      logic [15:0] masks [5];
      logic [31:0] ages  [5];
      req_beat_type b;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_REJECT_MASK;
      csr_write_data = '0;
      errors = 0;
      beats_checked = 0;
      mdl_reject = REJECT_MASK_RESET;
      mdl_max_age = MAX_AGE_RESET;
      mdl_now = '0;
      mdl_entries = 0;
      mdl_hosts = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
      addr_pool[0] = '1;
      addr_pool[1] = '0;
      foreach (link_pool[i]) begin
         len_pool[i] = 4'($urandom_range(0, 8));
         link_pool[i] = {$urandom, $urandom} & bytes_mask(len_pool[i]);
      end
      masks = '{16'h0000, 16'hffff, 16'h0061, 16'h0000, 16'h0008};
      ages  = '{32'd0, 32'hffffffff, 32'd90, 32'd3, 32'd1};
      masks[3] = 16'($urandom);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed beats under reset settings
      push_directed(MODE_UPDATE, 1, 16'h0002, 1, 0, '1, 64'hffffffff_0a000001,
                    64'hffff_0011_2233_4455, 4'd6);
      push_directed(MODE_LOOKUP, 0, 0, 0, 0, 0, 64'h0000_0000_0a000001, 0, 0);
      push_directed(MODE_UPDATE, 1, 0, 1, 1, '1, '1, 64'h0011_2233_4455, 4'd6);
      push_directed(MODE_LOOKUP, 1, '1, 1, 1, '1, '1, '1, '1);
      push_directed(MODE_UPDATE, 1, 16'h0080, 1, 0, 0, 64'h0a000001, 0, 4'd6);
      push_directed(MODE_UPDATE, 0, 0, 1, 0, 0, 64'h0a000002, 0, 4'd6);
      push_directed(MODE_UPDATE, 1, 0, 0, 0, 0, 64'h0a000002, 0, 4'd6);
      push_directed(MODE_UPDATE, 1, 16'h0001, 1, 0, 0, 64'h0a000002, 0, 4'd6);
      push_directed(MODE_UPDATE, 1, 16'h0020, 1, 0, 0, 64'h0a000002, 0, 4'd6);
      push_directed(MODE_UPDATE, 1, 16'h0040, 1, 0, 0, 64'h0a000002, 0, 4'd6);
      push_directed(MODE_UPDATE, 1, 0, 1, 0, 0, 64'h0a000002, '1, 4'd9);
      push_directed(MODE_UPDATE, 1, 0, 1, 0, 0, 64'h0a000002, '1, 4'd15);
      push_directed(MODE_UPDATE, 1, 0, 1, 0, 0, 64'h0a000003, '1, 4'd0);
      push_directed(MODE_UPDATE, 1, 0, 1, 1, 0, 0, '1, 4'd8);
      push_directed(MODE_UPDATE, 1, 0, 1, 1, 0, 0, '1, 4'd8);
      push_directed(MODE_TICK, 1, '1, 1, 1, '1, '1, '1, '1);
      push_directed(MODE_LOOKUP, 0, 0, 0, 1, 0, 0, 0, 0);
      push_directed(MODE_LOOKUP, 0, 0, 0, 0, 0, 64'h0a000009, 0, 0);
      push_directed(MODE_LOOKUP, 0, 0, 0, 1, 0, 64'h0a000003, 0, 0);
      push_directed(MODE_UNUSED, 1, 0, 1, 0, 0, 64'h0a000004, 0, 4'd2);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_REJECT_MASK, {16'd0, masks[p]});
         write_csr(CSR_MAX_AGE, ages[p]);
         for (int n = 0; n < 400; n++) begin
            b = random_beat();
            b.drain = (n == 200);
            pending_beats.push_back(b);
         end
         wait_idle();
      end
      write_csr(CSR_REJECT_MASK, {16'd0, REJECT_MASK_RESET});
      write_csr(CSR_MAX_AGE, MAX_AGE_RESET);
      for (int n = 0; n < 20; n++) pending_beats.push_back(make_beat(MODE_LOOKUP));
      wait_idle();

      $display("checked %0d beats: %0d added, %0d refreshed, %0d ignored, %0d ticks",
               beats_checked, status_seen[ST_ADDED], status_seen[ST_REFRESHED],
               status_seen[ST_IGNORED], status_seen[ST_TICK]);
      $display("table full %0d/%0d, link too long %0d, hits %0d fresh %0d stale, %0d misses",
               status_seen[ST_ENT_FULL], status_seen[ST_HOST_FULL], status_seen[ST_LINK_LONG],
               status_seen[ST_FRESH], status_seen[ST_STALE], status_seen[ST_MISS]);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("timeout with %0d results outstanding", expected_rsps.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
